/* hw/rtl/bsfr_pkg.sv */
// ----------------------------------------------------------------------------
// bsfr_pkg
// Shared types and constants of the bit stream frame receiver.
// ----------------------------------------------------------------------------
package bsfr_pkg;

  // Result kinds carried on the output tuser.
  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_PAYLOAD = 3'd1,
    KIND_CHECK   = 3'd2,
    KIND_REJECT  = 3'd3,
    KIND_ACCEPT  = 3'd4
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_PROBE_MODE   = 3'd0,
    REG_HIT_THRESH   = 3'd1,
    REG_REPEAT_ALLOW = 3'd2,
    REG_START_PAT    = 3'd3,
    REG_START_BUDGET = 3'd4
  } reg_idx_e;

  // Register reset values.
  localparam logic        ProbeModeRst   = 1'b1;
  localparam logic [31:0] HitThreshRst   = 32'd0;
  localparam logic [3:0]  RepeatAllowRst = 4'd4;
  localparam logic [7:0]  StartPatRst    = 8'd171;
  localparam logic [2:0]  StartBudgetRst = 3'd1;

  localparam logic [15:0] MinPayload     = 16'd46;
  localparam int unsigned LengthBits     = 16;

  typedef struct packed {
    logic        probe_mode;
    logic [31:0] hit_threshold;
    logic [3:0]  repeat_allowance;
    logic [7:0]  start_pattern;
    logic [2:0]  start_error_budget;
  } cfg_t;

  // Result item as held in the output register.
  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
    logic [10:0] payload_length;
    logic        length_clamped;
    logic        frame_last;
  } result_t;

endpackage

/* hw/rtl/bsfr_bit_slicer.sv */
// ----------------------------------------------------------------------------
// bsfr_bit_slicer
// Turns each cycle count into a bit by a threshold compare and registers it.
// ----------------------------------------------------------------------------
module bsfr_bit_slicer
  import bsfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        s_valid_i,
  output logic        s_ready_o,
  input  logic [31:0] s_count_i,
  output logic        bit_valid_o,
  output logic        bit_o,
  input  logic        bit_take_i
);

  logic valid_q, valid_d;
  logic bit_q, bit_d;
  logic load;

  // mode 1: hit when fast (count <= threshold); mode 0: count >= threshold
  always_comb begin
    if (cfg_i.probe_mode) begin
      bit_d = (s_count_i <= cfg_i.hit_threshold);
    end else begin
      bit_d = (s_count_i >= cfg_i.hit_threshold);
    end
  end

  assign s_ready_o = !valid_q || bit_take_i;
  assign load      = s_valid_i && s_ready_o;
  assign valid_d   = load || (valid_q && !bit_take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bit_q <= bit_d;
    end
  end

  assign bit_valid_o = valid_q;
  assign bit_o       = bit_q;

endmodule

/* hw/rtl/bsfr_deframer.sv */
// ----------------------------------------------------------------------------
// bsfr_deframer
// Preamble hunt, start check, header/payload/check word assembly and the
// result register.
// ----------------------------------------------------------------------------
module bsfr_deframer
  import bsfr_pkg::*;
#(
  parameter int unsigned PREAMBLE_BITS = 56,
  parameter int unsigned MAX_PAYLOAD   = 1500,
  parameter int unsigned HEADER_BITS   = 112
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    bit_valid_i,
  input  logic    bit_i,
  output logic    bit_take_o,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  localparam logic [5:0]  PreLim   = 6'(PREAMBLE_BITS);
  localparam logic [6:0]  HdrLim   = 7'(HEADER_BITS);
  localparam logic [6:0]  LenStart = 7'(HEADER_BITS - 16);
  localparam logic [6:0]  HdrLast  = 7'(HEADER_BITS - 1);
  localparam logic [15:0] MaxLen   = LengthBits'(MAX_PAYLOAD);

  logic [5:0]  pre_cnt_q, pre_cnt_d;
  logic        prev_bit_q, prev_bit_d;
  logic [3:0]  rep_left_q, rep_left_d;
  logic [3:0]  sbit_idx_q, sbit_idx_d;
  logic [3:0]  serr_left_q, serr_left_d;
  logic [6:0]  hdr_idx_q, hdr_idx_d;
  logic [2:0]  bib_q, bib_d;
  logic [7:0]  byte_q, byte_d;
  logic [15:0] len_q, len_d;
  logic [10:0] pay_idx_q, pay_idx_d;
  logic [31:0] chk_q, chk_d;
  logic [5:0]  chk_idx_q, chk_idx_d;
  logic        clamp_q, clamp_d;

  logic        emit;
  kind_e       kind;
  logic [31:0] value;
  logic        last;
  logic [7:0]  byte_full;
  logic [31:0] chk_full;
  logic [15:0] len_shifted;
  logic        want;
  logic        out_free;
  logic        out_valid_q;
  result_t     out_q;

  assign byte_full   = byte_q | ({7'd0, bit_i} << (3'd7 - bib_q));
  assign chk_full    = chk_q | ({31'd0, bit_i} << (5'd31 - chk_idx_q[4:0]));
  assign len_shifted = {len_q[14:0], bit_i};
  assign want        = cfg_i.start_pattern[3'd7 - sbit_idx_q[2:0]];

  always_comb begin
    pre_cnt_d   = pre_cnt_q;
    prev_bit_d  = prev_bit_q;
    rep_left_d  = rep_left_q;
    sbit_idx_d  = sbit_idx_q;
    serr_left_d = serr_left_q;
    hdr_idx_d   = hdr_idx_q;
    bib_d       = bib_q;
    byte_d      = byte_q;
    len_d       = len_q;
    pay_idx_d   = pay_idx_q;
    chk_d       = chk_q;
    chk_idx_d   = chk_idx_q;
    clamp_d     = clamp_q;
    emit        = 1'b0;
    kind        = KIND_HEADER;
    value       = 32'd0;
    last        = 1'b0;

    if (pre_cnt_q < PreLim) begin
      if (pre_cnt_q == 6'd0) begin
        if (!cfg_i.probe_mode && bit_i) begin
          rep_left_d = 4'd0;
          prev_bit_d = 1'b1;
          pre_cnt_d  = 6'd1;
        end else if (cfg_i.probe_mode && !bit_i) begin
          rep_left_d = 4'd0;
          prev_bit_d = 1'b0;
          pre_cnt_d  = 6'd2;
        end
      end else if (bit_i != prev_bit_q) begin
        pre_cnt_d  = pre_cnt_q + 6'd1;
        prev_bit_d = bit_i;
        rep_left_d = cfg_i.repeat_allowance;
      end else if (rep_left_q == 4'd0) begin
        pre_cnt_d  = 6'd0;
        rep_left_d = cfg_i.repeat_allowance;
      end else begin
        pre_cnt_d  = pre_cnt_q + 6'd1;
        rep_left_d = rep_left_q - 4'd1;
      end
    end else if (sbit_idx_q < 4'd8) begin
      if (bit_i != want) begin
        serr_left_d = serr_left_q - 4'd1;
      end
      if (sbit_idx_q == 4'd7) begin
        emit = 1'b1;
        if (serr_left_d[3]) begin
          // budget overdrawn: back to the preamble hunt
          kind        = KIND_REJECT;
          pre_cnt_d   = 6'd0;
          rep_left_d  = cfg_i.repeat_allowance;
          sbit_idx_d  = 4'd0;
          serr_left_d = {1'b0, cfg_i.start_error_budget};
        end else begin
          kind       = KIND_ACCEPT;
          sbit_idx_d = 4'd8;
        end
      end else begin
        sbit_idx_d = sbit_idx_q + 4'd1;
      end
    end else if (hdr_idx_q < HdrLim) begin
      if (bib_q == 3'd7) begin
        emit   = 1'b1;
        kind   = KIND_HEADER;
        value  = {24'd0, byte_full};
        byte_d = 8'd0;
        bib_d  = 3'd0;
      end else begin
        byte_d = byte_full;
        bib_d  = bib_q + 3'd1;
      end
      if (hdr_idx_q >= LenStart) begin
        len_d = len_shifted;
      end
      if (hdr_idx_q == HdrLast) begin
        if (len_d < MinPayload) begin
          len_d = MinPayload;
        end
        if (len_d > MaxLen) begin
          len_d   = MaxLen;
          clamp_d = 1'b1;
        end
      end
      hdr_idx_d = hdr_idx_q + 7'd1;
    end else if ({5'd0, pay_idx_q} < len_q) begin
      // leftover header bits carry into the first payload byte
      if (bib_q == 3'd7) begin
        emit      = 1'b1;
        kind      = KIND_PAYLOAD;
        value     = {24'd0, byte_full};
        byte_d    = 8'd0;
        bib_d     = 3'd0;
        pay_idx_d = pay_idx_q + 11'd1;
      end else begin
        byte_d = byte_full;
        bib_d  = bib_q + 3'd1;
      end
    end else if (chk_idx_q < 6'd32) begin
      chk_d = chk_full;
      if (chk_idx_q == 6'd31) begin
        emit  = 1'b1;
        kind  = KIND_CHECK;
        value = chk_full;
        last  = 1'b1;
      end
      chk_idx_d = chk_idx_q + 6'd1;
    end else begin
      // trailing sample after the check word: restart, keep previous bit
      pre_cnt_d   = 6'd0;
      rep_left_d  = cfg_i.repeat_allowance;
      sbit_idx_d  = 4'd0;
      serr_left_d = {1'b0, cfg_i.start_error_budget};
      hdr_idx_d   = 7'd0;
      bib_d       = 3'd0;
      byte_d      = 8'd0;
      len_d       = 16'd0;
      pay_idx_d   = 11'd0;
      chk_d       = 32'd0;
      chk_idx_d   = 6'd0;
      clamp_d     = 1'b0;
    end
  end

  assign out_free   = !out_valid_q || res_ready_i;
  assign bit_take_o = bit_valid_i && (!emit || out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_cnt_q   <= 6'd0;
      prev_bit_q  <= 1'b0;
      rep_left_q  <= RepeatAllowRst;
      sbit_idx_q  <= 4'd0;
      serr_left_q <= {1'b0, StartBudgetRst};
      hdr_idx_q   <= 7'd0;
      bib_q       <= 3'd0;
      byte_q      <= 8'd0;
      len_q       <= 16'd0;
      pay_idx_q   <= 11'd0;
      chk_q       <= 32'd0;
      chk_idx_q   <= 6'd0;
      clamp_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (bit_take_o) begin
        pre_cnt_q   <= pre_cnt_d;
        prev_bit_q  <= prev_bit_d;
        rep_left_q  <= rep_left_d;
        sbit_idx_q  <= sbit_idx_d;
        serr_left_q <= serr_left_d;
        hdr_idx_q   <= hdr_idx_d;
        bib_q       <= bib_d;
        byte_q      <= byte_d;
        len_q       <= len_d;
        pay_idx_q   <= pay_idx_d;
        chk_q       <= chk_d;
        chk_idx_q   <= chk_idx_d;
        clamp_q     <= clamp_d;
      end
      if (bit_take_o && emit) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (bit_take_o && emit) begin
      out_q.kind       <= kind;
      out_q.value      <= value;
      out_q.frame_last <= last;
      if (hdr_idx_d >= HdrLim) begin
        out_q.payload_length <= len_d[10:0];
        out_q.length_clamped <= clamp_d;
      end else begin
        out_q.payload_length <= 11'd0;
        out_q.length_clamped <= 1'b0;
      end
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

/* hw/rtl/bit_stream_frame_receiver_core.sv */
// ----------------------------------------------------------------------------
// bit_stream_frame_receiver_core
// Deframer for a stream of timing samples: preamble, start pattern, header,
// payload and check word.
// ----------------------------------------------------------------------------
// Each slave transaction carries one cycle count, which is sliced into one
// bit against hit_threshold (probe_mode 1: bit is 1 when count <= threshold;
// probe_mode 0: when count >= threshold). The receiver hunts for an
// alternating preamble of PREAMBLE_BITS bits (tolerating up to
// repeat_allowance repeated bits in a row), checks the 8-bit start_pattern
// within start_error_budget mismatches (tuser kind 3 on reject, 4 on
// accept), then sends header bytes (kind 0), payload bytes (kind 1) and the
// 32-bit check word (kind 2, tlast high). The payload length comes from the
// last 16 header bits, raised to 46 and saturated at MAX_PAYLOAD. The sample
// after the check word is dropped and the frame logic restarts. Most samples
// produce no master transaction. Throughput is one sample per clock while
// the master side keeps up; a sample that yields a result passes through
// the slicer's input register and then the result register before it is
// presented on the master side. The slave side keeps accepting while a
// result waits, until a second result is ready behind it. Configuration
// writes are taken every cycle and must only happen while the receiver is
// idle; indexes above 4 are ignored.
// ----------------------------------------------------------------------------
module bit_stream_frame_receiver_core
  import bsfr_pkg::*;
#(
  parameter int unsigned PREAMBLE_BITS = 56,
  parameter int unsigned MAX_PAYLOAD   = 1500,
  parameter int unsigned HEADER_BITS   = 112
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // sample stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] cycle_count
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] value, [42:32] payload_length,
                                      // [43] length_clamped, [47:44] zero
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast    // frame_last
);

  cfg_t    cfg_q;
  logic    bit_valid;
  logic    bit_val;
  logic    bit_take;
  result_t res;

  // Configuration registers; always ready, writes masked to field width.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.probe_mode         <= ProbeModeRst;
      cfg_q.hit_threshold      <= HitThreshRst;
      cfg_q.repeat_allowance   <= RepeatAllowRst;
      cfg_q.start_pattern      <= StartPatRst;
      cfg_q.start_error_budget <= StartBudgetRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PROBE_MODE:   cfg_q.probe_mode         <= cfg_data_i[0];
        REG_HIT_THRESH:   cfg_q.hit_threshold      <= cfg_data_i;
        REG_REPEAT_ALLOW: cfg_q.repeat_allowance   <= cfg_data_i[3:0];
        REG_START_PAT:    cfg_q.start_pattern      <= cfg_data_i[7:0];
        REG_START_BUDGET: cfg_q.start_error_budget <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Stage 1: threshold compare into the input register.
  bsfr_bit_slicer u_slicer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_count_i   (s_axis_tdata),
    .bit_valid_o (bit_valid),
    .bit_o       (bit_val),
    .bit_take_i  (bit_take)
  );

  // Stage 2: frame state update into the result register.
  bsfr_deframer #(
    .PREAMBLE_BITS (PREAMBLE_BITS),
    .MAX_PAYLOAD   (MAX_PAYLOAD),
    .HEADER_BITS   (HEADER_BITS)
  ) u_deframer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .bit_valid_i (bit_valid),
    .bit_i       (bit_val),
    .bit_take_o  (bit_take),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {4'd0, res.length_clamped, res.payload_length, res.value};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.frame_last;

endmodule

/* dv/bit_stream_frame_receiver_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_stream_frame_receiver_core_test
// Self-checking bench for the sample-stream deframer. Timing samples are
// generated from bit sequences (idle line, preambles with tolerated and
// excess repeats, start patterns inside and outside the error budget,
// header with length field, payload and check word), mixed with raw noise.
// A scoreboard slices and deframes every accepted sample and compares each
// master transaction field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module bit_stream_frame_receiver_core_test;
  import bsfr_pkg::*;

  localparam int unsigned PreambleBits = 56;
  localparam int unsigned MaxPayload   = 1500;
  localparam int unsigned HeaderBits   = 112;
  localparam int unsigned RegCount     = 5;     // indexes at or above this are ignored
  localparam int unsigned ItemTarget   = 900;   // samples before the closing frame
  localparam int unsigned FrameCost    = 700;   // typical full frame, short length field
  localparam int unsigned MinPhases    = 6;
  localparam int unsigned DrainCycles  = 4;     // two-stage pipeline plus margin
  localparam int unsigned IdleRun      = 17;    // beats any repeat allowance

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of configuration and frame state; predicts the
  // result of every accepted sample and checks the master side against it.
  // --------------------------------------------------------------------------
  class deframer_scoreboard;
    logic        probe_mode;
    logic [31:0] hit_threshold;
    logic [3:0]  repeat_allow;
    logic [7:0]  start_pat;
    logic [2:0]  start_budget;

    int unsigned preamble_len;
    logic        line_level;
    logic [3:0]  repeats_left;
    int unsigned start_idx;
    logic [3:0]  start_slack;   // goes negative (bit 3) when budget is exceeded
    int unsigned header_idx;
    int unsigned octet_bit;
    logic [7:0]  octet_acc;
    logic [15:0] length_acc;
    int unsigned payload_idx;
    logic [31:0] check_acc;
    int unsigned check_idx;
    logic        length_sat;

    result_t     frame_items[$];
    int unsigned errors;

    function new();
      probe_mode    = ProbeModeRst;
      hit_threshold = HitThreshRst;
      repeat_allow  = RepeatAllowRst;
      start_pat     = StartPatRst;
      start_budget  = StartBudgetRst;
      line_level    = 1'b0;
      errors        = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      preamble_len = 0;
      repeats_left = repeat_allow;
      start_idx    = 0;
      start_slack  = {1'b0, start_budget};
      header_idx   = 0;
      octet_bit    = 0;
      octet_acc    = '0;
      length_acc   = '0;
      payload_idx  = 0;
      check_acc    = '0;
      check_idx    = 0;
      length_sat   = 1'b0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_PROBE_MODE:   probe_mode    = data[0];
        REG_HIT_THRESH:   hit_threshold = data;
        REG_REPEAT_ALLOW: repeat_allow  = data[3:0];
        REG_START_PAT:    start_pat     = data[7:0];
        REG_START_BUDGET: start_budget  = data[2:0];
        default: ;
      endcase
    endfunction

    // MSB-first byte assembly; returns 1 when a byte is complete
    function bit shift_octet(bit b, output logic [7:0] octet);
      octet = '0;
      octet_acc[7 - octet_bit] = b;
      if (octet_bit >= 7) begin
        octet     = octet_acc;
        octet_acc = '0;
        octet_bit = 0;
        return 1'b1;
      end
      octet_bit++;
      return 1'b0;
    endfunction

    function void deframe_sample(logic [31:0] count);
      bit         b;
      bit         emit;
      logic [7:0] octet;
      result_t    r;

      b = probe_mode ? (count <= hit_threshold) : (count >= hit_threshold);
      emit = 1'b0;
      r.kind = KIND_HEADER;
      r.value = '0;
      r.payload_length = '0;
      r.length_clamped = 1'b0;
      r.frame_last = 1'b0;

      if (preamble_len < PreambleBits) begin
        if (preamble_len == 0) begin
          // hunt start: mode 0 on a one (counts one), mode 1 on a zero (counts two)
          if (!probe_mode && b) begin
            repeats_left = '0;
            line_level   = 1'b1;
            preamble_len = 1;
          end else if (probe_mode && !b) begin
            repeats_left = '0;
            line_level   = 1'b0;
            preamble_len = 2;
          end
        end else if (b != line_level) begin
          preamble_len++;
          line_level   = b;
          repeats_left = repeat_allow;
        end else if (repeats_left == 0) begin
          preamble_len = 0;
          repeats_left = repeat_allow;
        end else begin
          preamble_len++;
          repeats_left = repeats_left - 4'd1;
        end
      end else if (start_idx < 8) begin
        if (b != start_pat[7 - start_idx]) start_slack = start_slack - 4'd1;
        if (start_idx == 7) begin
          emit = 1'b1;
          if (start_slack[3]) begin
            r.kind       = KIND_REJECT;
            preamble_len = 0;
            repeats_left = repeat_allow;
            start_idx    = 0;
            start_slack  = {1'b0, start_budget};
          end else begin
            r.kind    = KIND_ACCEPT;
            start_idx = 8;
          end
        end else begin
          start_idx++;
        end
      end else if (header_idx < HeaderBits) begin
        if (shift_octet(b, octet)) begin
          emit    = 1'b1;
          r.kind  = KIND_HEADER;
          r.value = {24'd0, octet};
        end
        if (header_idx >= HeaderBits - 16) length_acc = {length_acc[14:0], b};
        if (header_idx == HeaderBits - 1) begin
          if (length_acc < MinPayload) length_acc = MinPayload;
          if (length_acc > 16'(MaxPayload)) begin
            length_acc = 16'(MaxPayload);
            length_sat = 1'b1;
          end
        end
        header_idx++;
      end else if (payload_idx < length_acc) begin
        if (shift_octet(b, octet)) begin
          emit    = 1'b1;
          r.kind  = KIND_PAYLOAD;
          r.value = {24'd0, octet};
          payload_idx++;
        end
      end else if (check_idx < 32) begin
        check_acc[31 - check_idx] = b;
        if (check_idx == 31) begin
          emit         = 1'b1;
          r.kind       = KIND_CHECK;
          r.value      = check_acc;
          r.frame_last = 1'b1;
        end
        check_idx++;
      end else begin
        // sample after the check word is dropped; line level is kept
        restart_frame();
      end

      if (emit) begin
        if (header_idx >= HeaderBits) begin
          r.payload_length = length_acc[10:0];
          r.length_clamped = length_sat;
        end
        frame_items.push_back(r);
      end
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      end
    endfunction

    function void check_result(result_t seen);
      result_t want;
      if (frame_items.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual kind %0d value 0x%0h",
                 $time, seen.kind, seen.value);
        return;
      end
      want = frame_items.pop_front();
      compare("kind", 32'(want.kind), 32'(seen.kind));
      compare("value", want.value, seen.value);
      compare("payload_length", 32'(want.payload_length), 32'(seen.payload_length));
      compare("length_clamped", 32'(want.length_clamped), 32'(seen.length_clamped));
      compare("frame_last", 32'(want.frame_last), 32'(seen.frame_last));
    endfunction

    function int unsigned pending();
      return frame_items.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT connections
  // --------------------------------------------------------------------------
  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i   = '0;
  logic [31:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;   // [31:0] cycle_count
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;         // [31:0] value, [42:32] payload_length,
                                     // [43] length_clamped, [47:44] zero
  logic [2:0]  m_axis_tuser;         // [2:0] kind
  logic        m_axis_tlast;         // frame_last

  bit_stream_frame_receiver_core #(
    .PREAMBLE_BITS(PreambleBits),
    .MAX_PAYLOAD  (MaxPayload),
    .HEADER_BITS  (HeaderBits)
  ) u_top (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

  deframer_scoreboard sb;

  // settings as seen by the stimulus generator
  logic        cur_mode   = ProbeModeRst;
  logic [31:0] cur_thr    = HitThreshRst;
  logic [3:0]  cur_allow  = RepeatAllowRst;
  logic [7:0]  cur_pat    = StartPatRst;
  logic [2:0]  cur_budget = StartBudgetRst;

  int unsigned sample_total = 0;
  int unsigned burst_left   = 0;
  int unsigned full_frames  = 0;

  // receiver stall pattern
  logic [5:0]  stall_step = '0;
  logic [15:0] stall_pat  = '1;
  result_t     seen;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Master-side ready follows a 16-bit pattern, renewed whenever stall_step wraps;
  // bit 0 is always set, which bounds every stall.
  always @(posedge clk_i) begin
    stall_step <= stall_step + 6'd1;
    if (stall_step == '0) begin
      stall_pat <= (($urandom_range(3, 0) == 0) ? 16'hFFFF : 16'($urandom)) | 16'h0001;
    end
    m_axis_tready <= stall_pat[stall_step[3:0]];
  end

  // Monitor: every handshake is sampled with the values it had at the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) sb.deframe_sample(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        seen.kind           = kind_e'(m_axis_tuser);
        seen.value          = m_axis_tdata[31:0];
        seen.payload_length = m_axis_tdata[42:32];
        seen.length_clamped = m_axis_tdata[43];
        seen.frame_last     = m_axis_tlast;
        sb.check_result(seen);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // One sample transaction; bursts of random length with random gaps between.
  task automatic send_sample(input logic [31:0] count);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(300, 50)
                                               : $urandom_range(24, 1);
      gap = $urandom_range(6, 0);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= count;
    do @(posedge clk_i); while (!s_axis_tready);
    sample_total++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic apply_settings(input logic m, input logic [31:0] thr, input logic [3:0] allow,
                                input logic [7:0] pat, input logic [2:0] budget);
    write_reg(REG_PROBE_MODE, {31'd0, m});
    write_reg(REG_HIT_THRESH, thr);
    write_reg(REG_REPEAT_ALLOW, {28'd0, allow} | ($urandom & 32'hFFFF_FFF0));
    write_reg(REG_START_PAT, {24'd0, pat});
    write_reg(REG_START_BUDGET, {29'd0, budget});
    // an unmapped index now and then must leave everything untouched
    if ($urandom_range(2, 0) == 0) write_reg(3'($urandom_range(7, RegCount)), $urandom);
    cfg_valid_i <= 1'b0;
    cur_mode   = m;
    cur_thr    = thr;
    cur_allow  = allow;
    cur_pat    = pat;
    cur_budget = budget;
  endtask

  // Sender holds off until every expected result is out, then lets the
  // pipeline run dry before anything else happens.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus generation
  // --------------------------------------------------------------------------
  function automatic bit frames_ok();
    return cur_mode ? (cur_thr != 32'hFFFF_FFFF) : (cur_thr != 32'd0);
  endfunction

  // Cycle count that slices to b under the current settings; favors the edges.
  function automatic logic [31:0] count_for(bit b);
    logic [31:0] lo;
    logic [31:0] hi;
    if (cur_mode) begin
      lo = b ? 32'd0 : cur_thr + 32'd1;
      hi = b ? cur_thr : 32'hFFFF_FFFF;
    end else begin
      lo = b ? cur_thr : 32'd0;
      hi = b ? 32'hFFFF_FFFF : cur_thr - 32'd1;
    end
    case ($urandom_range(3, 0))
      0: return lo;
      1: return hi;
      default: return lo + $urandom_range(hi - lo, 0);
    endcase
  endfunction

  task automatic send_bit(input bit b);
    send_sample(count_for(b));
  endtask

  // Line level that never starts a hunt
  task automatic send_idle(input int unsigned n);
    repeat (n) send_bit(cur_mode);
  endtask

  // Alternating preamble with tolerated repeats; broken ones run out of
  // tolerance partway through and drop back to the hunt.
  task automatic send_preamble(input bit broken);
    bit          level;
    int unsigned len;
    int unsigned rep_left;
    int unsigned break_at;
    send_idle($urandom_range(3, 1));
    level    = ~cur_mode;
    len      = cur_mode ? 2 : 1;
    rep_left = 0;
    break_at = $urandom_range(PreambleBits - IdleRun, 1);
    send_bit(level);
    while (len < PreambleBits) begin
      if (broken && len >= break_at) begin
        repeat (rep_left + 1) send_bit(level);
        return;
      end
      if (rep_left > 0 && $urandom_range(3, 0) == 0) begin
        rep_left--;
      end else begin
        level    = ~level;
        rep_left = cur_allow;
      end
      send_bit(level);
      len++;
    end
  endtask

  function automatic logic [15:0] pick_length();
    case ($urandom_range(9, 0))
      0: return 16'd0;
      1: return 16'd45;
      2: return 16'd46;
      3: return 16'd47;
      default: return 16'($urandom_range(64, 0));
    endcase
  endfunction

  // hdr_only stops after the length field, leaving the receiver in the payload
  task automatic send_frame(input bit reject, input logic [15:0] hdr_len, input bit hdr_only);
    int unsigned flips;
    int unsigned n_bytes;
    logic [7:0]  flip_mask;
    logic [7:0]  sfd;
    send_preamble(1'b0);
    flips = reject ? $urandom_range(8, cur_budget + 1) : $urandom_range(cur_budget, 0);
    flip_mask = '0;
    while ($countones(flip_mask) < flips) flip_mask[$urandom_range(7, 0)] = 1'b1;
    sfd = cur_pat ^ flip_mask;
    for (int i = 7; i >= 0; i--) send_bit(sfd[i]);
    if (reject) return;
    repeat (HeaderBits - 16) send_bit($urandom_range(1, 0));
    for (int i = 15; i >= 0; i--) send_bit(hdr_len[i]);
    if (hdr_only) return;
    n_bytes = (hdr_len < MinPayload) ? MinPayload
            : (hdr_len > MaxPayload) ? MaxPayload : hdr_len;
    repeat (8 * n_bytes) send_bit($urandom_range(1, 0));
    repeat (32) send_bit($urandom_range(1, 0));
    send_sample($urandom);   // dropped by the receiver
  endtask

  task automatic send_noise();
    repeat ($urandom_range(40, 5)) begin
      if (frames_ok() && $urandom_range(1, 0) == 0) send_bit($urandom_range(1, 0));
      else send_sample($urandom);
    end
    if (frames_ok()) send_idle(IdleRun);
  endtask

  task automatic pick_settings(input int unsigned phase);
    logic        m;
    logic [31:0] t;
    case (phase)
      0: apply_settings(1'b1, 32'd0, 4'd0, 8'h00, 3'd0);
      1: apply_settings(1'b0, 32'hFFFF_FFFF, 4'd15, 8'hFF, 3'd7);
      // thresholds at which every sample slices to one
      2: apply_settings(1'b1, 32'hFFFF_FFFF, 4'($urandom_range(15, 0)), 8'($urandom),
                        3'($urandom_range(7, 0)));
      3: apply_settings(1'b0, 32'd0, 4'($urandom_range(15, 0)), 8'($urandom),
                        3'($urandom_range(7, 0)));
      default: begin
        m = $urandom_range(1, 0);
        case ($urandom_range(3, 0))
          0: t = $urandom_range(3, 0);
          1: t = 32'hFFFF_FFFF - $urandom_range(3, 0);
          default: t = $urandom;
        endcase
        if (m && t == 32'hFFFF_FFFF) t = t - 32'd1;
        if (!m && t == 32'd0) t = 32'd1;
        apply_settings(m, t, 4'($urandom_range(15, 0)), 8'($urandom),
                       3'($urandom_range(7, 0)));
      end
    endcase
  endtask

  // Full frames are long, so they are only sent while they fit the sample
  // budget; the first frame-capable phase always opens with one.
  task automatic run_phase();
    int unsigned pick;
    if (!frames_ok()) begin
      send_noise();
      return;
    end
    send_idle(IdleRun);
    repeat ($urandom_range(3, 1)) begin
      pick = $urandom_range(19, 0);
      if (full_frames == 0 || (pick < 7 && sample_total + FrameCost <= ItemTarget)) begin
        send_frame(1'b0, pick_length(), 1'b0);
        full_frames++;
      end
      else if (pick < 13) send_frame(1'b1, 16'd0, 1'b0);
      else if (pick < 16) send_preamble(1'b1);
      else send_noise();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned phase;
    logic [15:0] big_len;

    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset settings (mode 1, threshold 0): idle line, hunt start on a zero,
    // an immediate repeat with no tolerance, then repeats until the allowance
    // runs out, plus count extremes.
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0001);
    send_sample(32'h0000_0000);
    send_sample(32'h8000_0000);
    repeat (5) send_sample(32'h0000_0000);
    send_sample(32'h0000_0000);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'hFFFF_FFFE);
    settle();

    // Mode 0: hunt starts on a one and counts it as one bit.
    apply_settings(1'b0, 32'h8000_0000, 4'd1, 8'hAB, 3'd1);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'hC000_0000);
    send_sample(32'h0000_0000);
    send_sample(32'h0000_0001);
    send_sample(32'h0000_0002);
    send_sample(32'h5555_5555);
    send_sample(32'hAAAA_AAAA);
    send_sample(32'h0000_FFFF);
    settle();

    phase = 0;
    while (phase < MinPhases || sample_total < ItemTarget) begin
      pick_settings(phase);
      run_phase();
      settle();
      phase++;
    end

    // One frame with an oversized length field to hit the saturation. The
    // clamped length and flag already show on the last header byte, so the
    // run ends inside its payload.
    pick_settings(phase);
    case ($urandom_range(2, 0))
      0: big_len = 16'(MaxPayload + 1);
      1: big_len = 16'hFFFF;
      default: big_len = 16'($urandom_range(65535, MaxPayload + 1));
    endcase
    send_idle(IdleRun);
    send_frame(1'b0, big_len, 1'b1);
    settle();
    repeat (8) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
